// ----- rtl/sst_pkg.sv -----
// Shared types and codes for the scoped symbol table.
package sst_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_IN_W = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 8;
   localparam int POPPED_W = 9;
   localparam int LIMIT_W  = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EXISTS      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_MANY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CONST       = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_SCOPE_LIMIT = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/scoped_symbol_table_unit.sv -----
// Scoped symbol table: entry memory, newest-first search sequencer and result register.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------------
//  req     | in        | req_valid req_ready req_command req_name_key req_is_const
//          |           | req_for_write
//  rsp     | out       | rsp_valid rsp_ready rsp_status rsp_slot rsp_popped_count
//          |           | rsp_shadowed
//  csr     | in        | csr_valid csr_ready csr_entry_limit (ready out of reset)
//
// Push goes straight to the finish state. Create/find scan the entries newest-first,
// one memory read per cycle, until a key match or the oldest entry. Pop scans the
// same way and removes the k entries of the current scope; the scan also reads the
// first entry of an outer scope unless the pop empties the table.
// One request is in flight at a time; the result register lets the next request in
// while the previous result waits. Synchronous reset clears count and scope and sets
// the limit to 255.
module scoped_symbol_table_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_SCOPE   = 255,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sst_pkg::CMD_W-1:0]        req_command,
   input  logic [sst_pkg::KEY_IN_W-1:0]     req_name_key,
   input  logic                             req_is_const,
   input  logic                             req_for_write,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sst_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sst_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [sst_pkg::POPPED_W-1:0]     rsp_popped_count,
   output logic                             rsp_shadowed,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sst_pkg::LIMIT_W-1:0]      csr_entry_limit
);

   localparam int KW   = (KEY_WIDTH < sst_pkg::KEY_IN_W) ? KEY_WIDTH : sst_pkg::KEY_IN_W;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int SW   = $clog2(MAX_SCOPE + 1);
   localparam int CMPW = (CW > sst_pkg::LIMIT_W) ? CW : sst_pkg::LIMIT_W;

   sst_pkg::state_type state_ff, state_in;

   logic [sst_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [KW-1:0]               key_ff, key_in;
   logic                        isc_ff, isc_in;
   logic                        wrt_ff, wrt_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               chk_ff, chk_in;
   logic [CW-1:0]               popped_ff, popped_in;
   logic                        found_ff, found_in;
   logic                        dup_ff, dup_in;
   logic                        fconst_ff, fconst_in;
   logic [AW-1:0]               pos_ff, pos_in;

   logic [CW-1:0]               count_ff, count_in;
   logic [SW-1:0]               scope_ff, scope_in;
   logic [sst_pkg::LIMIT_W-1:0] limit_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sst_pkg::STATUS_W-1:0] rsp_status_ff, fin_status;
   logic [sst_pkg::SLOT_W-1:0]   rsp_slot_ff, fin_slot;
   logic [sst_pkg::POPPED_W-1:0] rsp_popped_ff, fin_popped;
   logic                        rsp_shadowed_ff, fin_shadowed;

   logic [KW-1:0]               key_mem [TABLE_DEPTH];
   logic [SW-1:0]               scope_mem [TABLE_DEPTH];
   logic                        const_mem [TABLE_DEPTH];
   logic [KW-1:0]               rd_key_ff;
   logic [SW-1:0]               rd_scope_ff;
   logic                        rd_const_ff;

   logic          accept;
   logic          is_pop;
   logic          key_hit;
   logic          scope_ge;
   logic          stop;
   logic          remove;
   logic          srch_done;
   logic          issue;
   logic [CW-1:0] ptr_dec;
   logic [AW-1:0] rd_addr;
   logic          out_free;
   logic          finish_go;
   logic          full;
   logic          wr_en;

   assign req_ready        = (state_ff == sst_pkg::ST_IDLE) && !reset;
   assign accept           = req_valid && req_ready;
   assign csr_ready        = !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_popped_count = rsp_popped_ff;
   assign rsp_shadowed     = rsp_shadowed_ff;

   // search pipeline: one read issued per cycle, previous read checked
   assign is_pop    = (cmd_ff == sst_pkg::CMD_POP);
   assign key_hit   = (rd_key_ff == key_ff);
   assign scope_ge  = (rd_scope_ff >= scope_ff);
   assign stop      = pend_ff && (is_pop ? !scope_ge : key_hit);
   assign remove    = pend_ff && is_pop && scope_ge;
   assign srch_done = stop || (ptr_ff == '0);
   assign issue     = (state_ff == sst_pkg::ST_SEARCH) && !srch_done;
   assign ptr_dec   = ptr_ff - CW'(1);
   assign rd_addr   = ptr_dec[AW-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == sst_pkg::ST_FINISH) && out_free;
   assign full      = (CMPW'(count_ff) >= CMPW'(limit_ff)) ||
                      (count_ff >= CW'(TABLE_DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == sst_pkg::CMD_PUSH) begin
                  state_in = sst_pkg::ST_FINISH;
               end else if (req_command == sst_pkg::CMD_POP && scope_ff == '0) begin
                  state_in = sst_pkg::ST_FINISH;
               end else begin
                  state_in = sst_pkg::ST_SEARCH;
               end
            end
         end
         sst_pkg::ST_SEARCH: begin
            if (srch_done) begin
               state_in = sst_pkg::ST_FINISH;
            end
         end
         sst_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sst_pkg::ST_IDLE;
            end
         end
         default: state_in = sst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      isc_in    = isc_ff;
      wrt_in    = wrt_ff;
      ptr_in    = ptr_ff;
      pend_in   = 1'b0;
      chk_in    = chk_ff;
      popped_in = popped_ff;
      found_in  = found_ff;
      dup_in    = dup_ff;
      fconst_in = fconst_ff;
      pos_in    = pos_ff;
      if (accept) begin
         cmd_in    = req_command;
         key_in    = req_name_key[KW-1:0];
         isc_in    = req_is_const;
         wrt_in    = req_for_write;
         ptr_in    = count_ff;
         popped_in = '0;
         found_in  = 1'b0;
      end else if (state_ff == sst_pkg::ST_SEARCH) begin
         popped_in = popped_ff + CW'(remove);
         if (issue) begin
            pend_in = 1'b1;
            ptr_in  = ptr_dec;
            chk_in  = rd_addr;
         end
         if (stop && !is_pop) begin
            found_in  = 1'b1;
            dup_in    = scope_ge;
            fconst_in = rd_const_ff;
            pos_in    = chk_ff;
         end
      end
   end

   always_comb begin
      fin_status   = sst_pkg::STAT_OK;
      fin_slot     = '0;
      fin_popped   = '0;
      fin_shadowed = 1'b0;
      count_in     = count_ff;
      scope_in     = scope_ff;
      wr_en        = 1'b0;
      case (cmd_ff)
         sst_pkg::CMD_PUSH: begin
            if (scope_ff >= SW'(MAX_SCOPE)) begin
               fin_status = sst_pkg::STAT_SCOPE_LIMIT;
            end else begin
               scope_in = scope_ff + SW'(1);
            end
         end
         sst_pkg::CMD_POP: begin
            if (scope_ff == '0) begin
               fin_status = sst_pkg::STAT_SCOPE_LIMIT;
            end else begin
               fin_popped = sst_pkg::POPPED_W'(popped_ff);
               count_in   = count_ff - popped_ff;
               scope_in   = scope_ff - SW'(1);
            end
         end
         sst_pkg::CMD_CREATE: begin
            if (found_ff && dup_ff) begin
               fin_status = sst_pkg::STAT_EXISTS;
            end else if (full) begin
               fin_status = sst_pkg::STAT_TOO_MANY;
            end else begin
               wr_en        = finish_go;
               fin_slot     = sst_pkg::SLOT_W'(count_ff);
               fin_shadowed = found_ff;
               count_in     = count_ff + CW'(1);
            end
         end
         sst_pkg::CMD_FIND: begin
            if (!found_ff) begin
               fin_status = sst_pkg::STAT_NOT_FOUND;
            end else if (wrt_ff && fconst_ff) begin
               fin_status = sst_pkg::STAT_CONST;
            end else begin
               fin_slot = sst_pkg::SLOT_W'(pos_ff);
            end
         end
         default: fin_status = sst_pkg::STAT_OK;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[count_ff[AW-1:0]]   <= key_ff;
         scope_mem[count_ff[AW-1:0]] <= scope_ff;
         const_mem[count_ff[AW-1:0]] <= isc_ff;
      end
      if (issue) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_scope_ff <= scope_mem[rd_addr];
         rd_const_ff <= const_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      isc_ff    <= isc_in;
      wrt_ff    <= wrt_in;
      ptr_ff    <= ptr_in;
      chk_ff    <= chk_in;
      popped_ff <= popped_in;
      found_ff  <= found_in;
      dup_ff    <= dup_in;
      fconst_ff <= fconst_in;
      pos_ff    <= pos_in;
      if (finish_go) begin
         rsp_status_ff   <= fin_status;
         rsp_slot_ff     <= fin_slot;
         rsp_popped_ff   <= fin_popped;
         rsp_shadowed_ff <= fin_shadowed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         scope_ff     <= '0;
         limit_ff     <= sst_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_go) begin
            count_ff <= count_in;
            scope_ff <= scope_in;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_entry_limit;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_scope_bound: assert property (@(posedge clock) disable iff (reset)
      scope_ff <= SW'(MAX_SCOPE))
      else $error("scope level above maximum");

   a_create_grows: assert property (@(posedge clock) disable iff (reset)
      finish_go && cmd_ff == sst_pkg::CMD_CREATE && fin_status == sst_pkg::STAT_OK
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("successful create did not append");

   a_err_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != sst_pkg::STAT_OK
      |-> rsp_slot_ff == '0 && !rsp_shadowed_ff)
      else $error("error response carries slot or shadow flag");

endmodule
